// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the drift check block.
// Needs nothing else; each macro wraps one clocked concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, quiet while reset is high.
`define GFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gfd assertion failed");

// Check that an expression never holds.
`define GFD_ASSERT_NEVER(label, clk, rst, expr) \
   `GFD_ASSERT(label, clk, rst, !(expr))

`endif

// File: rtl/gfd_pkg.sv
// Types, constants and helper functions of the GPS fix drift check.
// No dependencies; used by the CORDIC, the root/divide unit, the top level and the bench.
`timescale 1ns / 1ps

package gfd_pkg;

   localparam int DW  = 36;   // CORDIC and multiplier operand width
   localparam int PW  = 72;   // product width
   localparam int UW  = 32;   // sine / cosine word width (Q30, clamped)
   localparam int AW  = 61;   // haversine term width (0 .. 2^60)
   localparam int SQW = 64;   // square root / divide unit width
   localparam int IW  = 6;    // arctangent table index width

   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS  = 64;

   localparam logic signed [34:0]   TURN_UNITS      = 35'sd7200000000;
   localparam logic [32:0]          QUARTER_UNITS   = 33'd1800000000;
   localparam logic signed [DW-1:0] RAD_PER_UNIT    = 36'sd4024455254;
   localparam logic signed [DW-1:0] CORDIC_INV_GAIN = 36'sd652032874;
   localparam logic signed [DW-1:0] EARTH_RADIUS_CM = 36'sd636962875;
   localparam logic signed [DW-1:0] ONE_Q30         = 36'sd1073741824;
   localparam logic [SQW-1:0]       ONE_Q60         = 64'h1000_0000_0000_0000;
   localparam logic [30:0]          DRIFT_RESET     = 31'd50000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TLOAD, ST_TQUAD, ST_TMULK, ST_TZ, ST_TCORD, ST_TRES1, ST_TRES2,
      ST_TRES3, ST_TSTORE, ST_APM, ST_AP, ST_ATM, ST_AT, ST_AS1, ST_AS2, ST_ASUM,
      ST_SQY, ST_SQYW, ST_SQX, ST_SQXW, ST_VEC, ST_VECW, ST_DIV, ST_DIVW,
      ST_DMUL, ST_DIST, ST_DONE
   } state_type;

   typedef enum logic [1:0] {JOB_DLAT, JOB_DLON, JOB_CLAT, JOB_CPREV} job_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctl_type;

   typedef struct packed {
      logic start;
      logic divide;
   } sqdiv_ctl_type;

   function automatic logic signed [DW-1:0] atan_step(input logic [IW-1:0] i);
      logic signed [DW-1:0] r;
      case (i)
         6'd0: r = 36'sd843314856;
         6'd1: r = 36'sd497837829;
         6'd2: r = 36'sd263043836;
         6'd3: r = 36'sd133525158;
         6'd4: r = 36'sd67021686;
         6'd5: r = 36'sd33543515;
         6'd6: r = 36'sd16775850;
         6'd7: r = 36'sd8388437;
         6'd8: r = 36'sd4194282;
         6'd9: r = 36'sd2097149;
         default: begin
            if (i <= 6'd30) r = DW'(64'd1 << (6'd30 - i));
            else            r = '0;
         end
      endcase
      return r;
   endfunction

   function automatic logic signed [UW-1:0] clamp_unit(input logic signed [DW-1:0] v);
      logic signed [UW-1:0] r;
      if (v > ONE_Q30)       r = UW'(ONE_Q30);
      else if (v < -ONE_Q30) r = -UW'(ONE_Q30);
      else                   r = UW'(v);
      return r;
   endfunction

endpackage

// File: rtl/gfd_req_if.sv
// Valid/ready channel carrying one GPS fix word.
// Depends on nothing.
`timescale 1ns / 1ps

interface gfd_req_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] latitude;
   logic signed [31:0] longitude;

   modport source (output valid, output latitude, output longitude, input ready);
   modport sink   (input valid, input latitude, input longitude, output ready);
endinterface

// File: rtl/gfd_rsp_if.sv
// Valid/ready channel carrying one distance result word.
// Depends on nothing.
`timescale 1ns / 1ps

interface gfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] distance_cm;
   logic        zero_move;
   logic        drift_flag;
   logic        first_fix;

   modport source (output valid, output distance_cm, output zero_move,
                   output drift_flag, output first_fix, input ready);
   modport sink   (input valid, input distance_cm, input zero_move,
                   input drift_flag, input first_fix, output ready);
endinterface

// File: rtl/gfd_cordic.sv
// Shared CORDIC unit: one rotation or vectoring step per cycle.
// Depends on gfd_pkg for widths, control struct and the arctangent table.
`timescale 1ns / 1ps

module gfd_cordic import gfd_pkg::*; #(
   parameter int STEPS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cordic_ctl_type       ctl,
   input  logic signed [DW-1:0] x_in,
   input  logic signed [DW-1:0] y_in,
   input  logic signed [DW-1:0] z_in,
   output logic signed [DW-1:0] x_out,
   output logic signed [DW-1:0] y_out,
   output logic signed [DW-1:0] z_out,
   output logic                 done
);

   localparam int SW = $clog2(STEPS);

   logic signed [DW-1:0] x_ff, y_ff, z_ff, x_in_n, y_in_n, z_in_n;
   logic signed [DW-1:0] xs, ys, ang;
   logic [SW-1:0]        step_ff;
   logic                 busy_ff, vec_ff, done_ff, go_pos;

   assign xs  = x_ff >>> step_ff;
   assign ys  = y_ff >>> step_ff;
   assign ang = atan_step(IW'(step_ff));
   // rotation drives z to zero, vectoring drives y to zero
   assign go_pos = vec_ff ? (y_ff >= 0) : (z_ff >= 0);

   always_comb begin
      if (vec_ff == go_pos) begin
         x_in_n = x_ff + ys;
         y_in_n = y_ff - xs;
      end else begin
         x_in_n = x_ff - ys;
         y_in_n = y_ff + xs;
      end
      z_in_n = go_pos ? z_ff - ang : z_ff + ang;
      if (vec_ff) z_in_n = go_pos ? z_ff + ang : z_ff - ang;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         vec_ff  <= 1'b0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
         vec_ff  <= ctl.vectoring;
      end else if (busy_ff) begin
         step_ff <= step_ff + SW'(1);
         if (step_ff == SW'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end else if (busy_ff) begin
         x_ff <= x_in_n;
         y_ff <= y_in_n;
         z_ff <= z_in_n;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

// File: rtl/gfd_sqdiv.sv
// Shared restoring unit: integer square root or unsigned divide, one bit a cycle.
// Depends on gfd_pkg for widths, step counts and the control struct.
`timescale 1ns / 1ps

module gfd_sqdiv import gfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sqdiv_ctl_type   ctl,
   input  logic [SQW-1:0]  op_a,
   input  logic [DW-1:0]   op_b,
   output logic [SQW-1:0]  result,
   output logic            done
);

   logic [SQW-1:0] val_ff, res_ff, bit_ff, minuend, subtrahend, diff;
   logic [DW-1:0]  dvs_ff;
   logic [6:0]     cnt_ff;
   logic           busy_ff, div_ff, done_ff, ge;

   // one subtractor serves both the root trial and the divide trial
   always_comb begin
      if (div_ff) begin
         minuend    = {val_ff[SQW-2:0], res_ff[SQW-1]};
         subtrahend = SQW'(dvs_ff);
      end else begin
         minuend    = val_ff;
         subtrahend = res_ff + bit_ff;
      end
      ge   = minuend >= subtrahend;
      diff = minuend - subtrahend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         div_ff  <= ctl.divide;
         cnt_ff  <= ctl.divide ? 7'(DIV_STEPS - 1) : 7'(SQRT_STEPS - 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         dvs_ff <= op_b;
         bit_ff <= SQW'(64'd1 << 60);
         if (ctl.divide) begin
            val_ff <= '0;
            res_ff <= op_a;
         end else begin
            val_ff <= op_a;
            res_ff <= '0;
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            val_ff <= ge ? diff : minuend;
            res_ff <= {res_ff[SQW-2:0], ge};
         end else begin
            if (ge) begin
               val_ff <= diff;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
      end
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

// File: rtl/gps_fix_distance_drift_check.sv
// GPS fix distance and drift check: haversine distance to the previous fix, in cm.
// Computed by four CORDIC sine/cosine passes, two 31-step square roots, one CORDIC
// arctangent and a 64-step divide on shared units; exact angles and a zero move finish
// sooner. One fix at a time: a new fix is taken only in the idle state, and the first
// fix goes straight to the result without a distance pass.
// Reset (synchronous): no previous fix, drift limit 50000 cm, output empty.
`timescale 1ns / 1ps

module gps_fix_distance_drift_check import gfd_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic        clock,
   input  logic        reset,
   gfd_req_if.sink     req_bus,
   gfd_rsp_if.source   rsp_bus,
   input  logic        csr_write_en,
   input  logic [30:0] csr_write_data
);

   // ---- state --------------------------------------------------------------
   state_type            state_ff, state_in;
   job_type              job_ff;
   logic signed [30:0]   cur_lat_ff, prev_lat_ff;
   logic signed [31:0]   cur_lon_ff, prev_lon_ff;
   logic                 have_prev_ff;
   logic [30:0]          drift_ff;

   logic [32:0]          t_ff;        // angle reduced into one turn, 5e-8 degree
   logic [1:0]           quad_ff;
   logic signed [UW-1:0] xr_ff, yr_ff, s1_ff, s2_ff, c1_ff, c2_ff;
   logic signed [PW-1:0] mul_ff, zy_ff, ss_ff;
   logic signed [DW-1:0] p_ff, tt_ff, zf_ff;
   logic [AW-1:0]        a_ff;
   logic [30:0]          ysq_ff, xsq_ff;
   logic [30:0]          dist_ff;
   logic                 first_ff;

   logic                 rsp_valid_ff;
   logic [30:0]          rsp_dist_ff;
   logic                 rsp_zero_ff, rsp_drift_ff, rsp_first_ff;

   // ---- shared units -------------------------------------------------------
   cordic_ctl_type       cord_ctl;
   sqdiv_ctl_type        sd_ctl;
   logic signed [DW-1:0] cx_in, cy_in, cz_in, cx, cy, cz;
   logic                 cord_done, sd_done;
   logic [SQW-1:0]       sd_a, sd_res;
   logic signed [DW-1:0] mul_a, mul_b;

   gfd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .ctl   (cord_ctl),
      .x_in  (cx_in),
      .y_in  (cy_in),
      .z_in  (cz_in),
      .x_out (cx),
      .y_out (cy),
      .z_out (cz),
      .done  (cord_done)
   );

   gfd_sqdiv u_sqdiv (
      .clock  (clock),
      .reset  (reset),
      .ctl    (sd_ctl),
      .op_a   (sd_a),
      .op_b   (cx),
      .result (sd_res),
      .done   (sd_done)
   );

   // ---- datapath helpers ---------------------------------------------------
   logic signed [34:0]   trig_v, trig_t;
   logic signed [PW-1:0] z0_sum, half_sum;
   logic signed [DW-1:0] z0, x_fin, y_fin, qt, c_op;
   logic signed [UW-1:0] sn, cs;
   logic signed [PW:0]   a_sum;
   logic [DW-1:0]        mag;
   logic [32:0]          mag_cap;
   logic [PW-31:0]       dist_wide;
   logic                 rsp_free;

   // angle argument of the current sine/cosine pass, half-angle scaling is implicit
   always_comb begin
      case (job_ff)
         JOB_DLAT:  trig_v = 35'(cur_lat_ff) - 35'(prev_lat_ff);
         JOB_DLON:  trig_v = 35'(cur_lon_ff) - 35'(prev_lon_ff);
         JOB_CLAT:  trig_v = 35'(cur_lat_ff) <<< 1;
         JOB_CPREV: trig_v = 35'(prev_lat_ff) <<< 1;
         default:   trig_v = '0;
      endcase
      trig_t = trig_v[34] ? trig_v + TURN_UNITS : trig_v;
   end

   assign z0_sum   = mul_ff + PW'(64'd1 << 31);
   assign z0       = z0_sum[DW+31:32];
   assign half_sum = mul_ff + PW'(64'd1 << 29);
   assign x_fin    = cx - DW'(zy_ff >>> 30);
   assign y_fin    = cy + DW'(mul_ff >>> 30);
   assign a_sum    = (PW+1)'(ss_ff) + (PW+1)'(mul_ff);
   assign qt       = sd_res[DW-1:0];
   assign mag      = cy[DW-1] ? -cy : cy;
   assign mag_cap  = (mag > DW'(64'd1 << 32)) ? 33'h1_0000_0000 : mag[32:0];
   assign c_op     = zf_ff[DW-1] ? '0 : {zf_ff[DW-2:0], 1'b0};
   assign dist_wide = half_sum[PW-1:30];
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // rotate the first-quadrant result into the quadrant of the angle
   always_comb begin
      case (quad_ff)
         2'd0:    begin cs = xr_ff;  sn = yr_ff;  end
         2'd1:    begin cs = -yr_ff; sn = xr_ff;  end
         2'd2:    begin cs = -xr_ff; sn = -yr_ff; end
         default: begin cs = yr_ff;  sn = -xr_ff; end
      endcase
   end

   // ---- sequencer: next state and unit controls ---------------------------
   always_comb begin
      state_in       = state_ff;
      cord_ctl       = '0;
      sd_ctl         = '0;
      cx_in          = CORDIC_INV_GAIN;
      cy_in          = '0;
      cz_in          = z0;
      sd_a           = SQW'(a_ff);
      mul_a          = '0;
      mul_b          = '0;
      req_bus.ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) state_in = have_prev_ff ? ST_TLOAD : ST_DONE;
         end
         ST_TLOAD: state_in = ST_TQUAD;
         ST_TQUAD: begin
            if (t_ff < QUARTER_UNITS) state_in = (t_ff == '0) ? ST_TSTORE : ST_TMULK;
         end
         ST_TMULK: begin
            mul_a    = DW'(t_ff);
            mul_b    = RAD_PER_UNIT;
            state_in = ST_TZ;
         end
         ST_TZ: begin
            cord_ctl.start = 1'b1;
            state_in       = ST_TCORD;
         end
         ST_TCORD: if (cord_done) state_in = ST_TRES1;
         ST_TRES1: begin
            mul_a    = cz;
            mul_b    = cy;
            state_in = ST_TRES2;
         end
         ST_TRES2: begin
            mul_a    = cz;
            mul_b    = cx;
            state_in = ST_TRES3;
         end
         ST_TRES3: state_in = ST_TSTORE;
         ST_TSTORE: state_in = (job_ff == JOB_CPREV) ? ST_APM : ST_TLOAD;
         ST_APM: begin
            mul_a    = DW'(c1_ff);
            mul_b    = DW'(c2_ff);
            state_in = ST_AP;
         end
         ST_AP: state_in = ST_ATM;
         ST_ATM: begin
            mul_a    = p_ff;
            mul_b    = DW'(s2_ff);
            state_in = ST_AT;
         end
         ST_AT: state_in = ST_AS1;
         ST_AS1: begin
            mul_a    = DW'(s1_ff);
            mul_b    = DW'(s1_ff);
            state_in = ST_AS2;
         end
         ST_AS2: begin
            mul_a    = tt_ff;
            mul_b    = DW'(s2_ff);
            state_in = ST_ASUM;
         end
         ST_ASUM: state_in = ST_SQY;
         ST_SQY: begin
            sd_ctl.start = 1'b1;
            state_in     = ST_SQYW;
         end
         ST_SQYW: if (sd_done) state_in = ST_SQX;
         ST_SQX: begin
            sd_ctl.start = 1'b1;
            sd_a         = ONE_Q60 - SQW'(a_ff);
            state_in     = ST_SQXW;
         end
         ST_SQXW: if (sd_done) state_in = ST_VEC;
         ST_VEC: begin
            cx_in              = DW'(xsq_ff);
            cy_in              = DW'(ysq_ff);
            cz_in              = '0;
            cord_ctl.start     = (ysq_ff != '0);
            cord_ctl.vectoring = 1'b1;
            state_in           = (ysq_ff != '0) ? ST_VECW : ST_DMUL;
         end
         ST_VECW: if (cord_done) state_in = (cx > 0) ? ST_DIV : ST_DMUL;
         ST_DIV: begin
            sd_ctl.start  = 1'b1;
            sd_ctl.divide = 1'b1;
            sd_a          = SQW'(mag_cap) << 30;
            state_in      = ST_DIVW;
         end
         ST_DIVW: if (sd_done) state_in = ST_DMUL;
         ST_DMUL: begin
            mul_a    = c_op;
            mul_b    = EARTH_RADIUS_CM;
            state_in = ST_DIST;
         end
         ST_DIST: state_in = ST_DONE;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---- control registers --------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
         drift_ff     <= DRIFT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) drift_ff <= csr_write_data;
         if (state_ff == ST_DONE && rsp_free) begin
            // hand the word over and keep this fix for the next one
            rsp_valid_ff <= 1'b1;
            prev_lat_ff  <= cur_lat_ff;
            prev_lon_ff  <= cur_lon_ff;
            have_prev_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- datapath registers -------------------------------------------------
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      case (state_ff)
         ST_IDLE: begin
            cur_lat_ff <= req_bus.latitude;
            cur_lon_ff <= req_bus.longitude;
            job_ff     <= JOB_DLAT;
            dist_ff    <= '0;
            first_ff   <= !have_prev_ff;
         end
         ST_TLOAD: begin
            t_ff    <= trig_t[32:0];
            quad_ff <= 2'd0;
            xr_ff   <= UW'(ONE_Q30);   // exact quarter turn: cos 1, sin 0
            yr_ff   <= '0;
         end
         ST_TQUAD: begin
            if (t_ff >= QUARTER_UNITS) begin
               t_ff    <= t_ff - QUARTER_UNITS;
               quad_ff <= quad_ff + 2'd1;
            end
         end
         ST_TRES2: zy_ff <= mul_ff;
         ST_TRES3: begin
            xr_ff <= clamp_unit(x_fin);
            yr_ff <= clamp_unit(y_fin);
         end
         ST_TSTORE: begin
            case (job_ff)
               JOB_DLAT:  s1_ff <= sn;
               JOB_DLON:  s2_ff <= sn;
               JOB_CLAT:  c1_ff <= cs;
               JOB_CPREV: c2_ff <= cs;
               default:   s1_ff <= sn;
            endcase
            job_ff <= job_type'(job_ff + 2'd1);
         end
         ST_AP:   p_ff  <= half_sum[DW+29:30];
         ST_AT:   tt_ff <= half_sum[DW+29:30];
         ST_AS2:  ss_ff <= mul_ff;
         ST_ASUM: begin
            if (a_sum[PW])                        a_ff <= '0;
            else if (a_sum > (PW+1)'(ONE_Q60))    a_ff <= AW'(ONE_Q60);
            else                                  a_ff <= a_sum[AW-1:0];
         end
         ST_SQYW: ysq_ff <= sd_res[30:0];
         ST_SQXW: xsq_ff <= sd_res[30:0];
         ST_VEC:  zf_ff  <= '0;
         ST_VECW: zf_ff  <= cz;
         ST_DIVW: if (sd_done) zf_ff <= cy[DW-1] ? zf_ff - qt : zf_ff + qt;
         ST_DIST: begin
            // saturate to the widest distance the port can show
            if (|dist_wide[PW-31:31]) dist_ff <= 31'h7FFF_FFFF;
            else                      dist_ff <= dist_wide[30:0];
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_dist_ff  <= dist_ff;
               rsp_first_ff <= first_ff;
               rsp_zero_ff  <= !first_ff && (dist_ff == '0);
               rsp_drift_ff <= !first_ff && (dist_ff > drift_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.distance_cm = rsp_dist_ff;
   assign rsp_bus.zero_move   = rsp_zero_ff;
   assign rsp_bus.drift_flag  = rsp_drift_ff;
   assign rsp_bus.first_fix   = rsp_first_ff;

endmodule

// File: rtl/gfd_checker.sv
// Port-level checker for the drift check block, bound to the top level.
// Depends on assert_macros.svh and the top level's ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] distance_cm,
   input logic        zero_move,
   input logic        drift_flag,
   input logic        first_fix
);

   // a word waiting on the output stays offered
   `GFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   // one fix at a time: busy right after taking a word
   `GFD_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)
   // the first fix carries no distance and no flags
   `GFD_ASSERT_NEVER(a_first_clean, clock, reset,
      rsp_valid && first_fix && (zero_move || drift_flag || distance_cm != 31'd0))
   // zero move matches a zero distance and excludes drift
   `GFD_ASSERT(a_zero_flag, clock, reset,
      rsp_valid && !first_fix |-> (zero_move == (distance_cm == 31'd0)) && !(zero_move && drift_flag))

endmodule

bind gps_fix_distance_drift_check gfd_checker u_gfd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .distance_cm (rsp_bus.distance_cm),
   .zero_move   (rsp_bus.zero_move),
   .drift_flag  (rsp_bus.drift_flag),
   .first_fix   (rsp_bus.first_fix)
);

// File: tb/testbench.sv
// Self-checking bench for the GPS fix distance and drift check block.
// Depends on gfd_pkg, gfd_req_if, gfd_rsp_if and the block's top level.
`timescale 1ns / 1ps

typedef struct {
   logic [30:0] distance_cm;
   logic        zero_move;
   logic        drift_flag;
   logic        first_fix;
} fix_result_type;

// Scoreboard: a bit-true haversine predictor plus the queue of expected words.
class drift_scoreboard;
   longint         last_lat;
   longint         last_lon;
   bit             have_last;
   logic [30:0]    drift_limit;
   fix_result_type pending[$];
   int             errors;
   int             checked;
   int             drifts_seen;
   int             zeros_seen;

   function new();
      last_lat    = 0;
      last_lon    = 0;
      have_last   = 0;
      drift_limit = gfd_pkg::DRIFT_RESET;
      errors      = 0;
      checked     = 0;
      drifts_seen = 0;
      zeros_seen  = 0;
   endfunction

   function longint arctan_q30(int i);
      longint tbl[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                          33543515, 16775850, 8388437, 4194282, 2097149};
      if (i < 10) return tbl[i];
      if (i <= 30) return longint'(1) << (30 - i);
      return 0;
   endfunction

   function longint clamp_q30(longint v);
      if (v > (longint'(1) << 30)) return longint'(1) << 30;
      if (v < -(longint'(1) << 30)) return -(longint'(1) << 30);
      return v;
   endfunction

   // Sine and cosine of an angle in units of 5e-8 degree, Q30.
   function void sin_cos(longint v, output longint sn, output longint cs);
      longint t, q, r, x, y, z, xs, ys, xo, c0, s0;
      t = v % 64'sd7200000000;
      if (t < 0) t += 64'sd7200000000;
      q = t / 64'sd1800000000;
      r = t - q * 64'sd1800000000;
      if (r == 0) begin
         c0 = longint'(1) << 30;
         s0 = 0;
      end else begin
         z = (r * 64'sd4024455254 + (longint'(1) << 31)) >>> 32;
         x = 652032874;
         y = 0;
         for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= arctan_q30(i);
            end else begin
               x += ys; y -= xs; z += arctan_q30(i);
            end
         end
         xo = x;
         x -= (z * y) >>> 30;
         y += (z * xo) >>> 30;
         c0 = clamp_q30(x);
         s0 = clamp_q30(y);
      end
      case (q)
         0: begin cs = c0;  sn = s0;  end
         1: begin cs = -s0; sn = c0;  end
         2: begin cs = -c0; sn = -s0; end
         default: begin cs = s0; sn = -c0; end
      endcase
   endfunction

   function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function longint atan2_q30(longint x, longint y);
      longint z, xs, ys;
      longint unsigned mag, qt;
      z = 0;
      if (y == 0) return 0;
      for (int i = 0; i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += arctan_q30(i);
         end else begin
            x -= ys; y += xs; z -= arctan_q30(i);
         end
      end
      if (x > 0) begin
         mag = (y < 0) ? -y : y;
         if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
         qt = (mag << 30) / longint'(x);
         z += (y < 0) ? -longint'(qt) : longint'(qt);
      end
      return z;
   endfunction

   function longint haversine_cm(longint lat, longint lon);
      longint s1, s2, c1, c2, dummy, p, t, a, z, d;
      sin_cos(lat - last_lat, s1, dummy);
      sin_cos(lon - last_lon, s2, dummy);
      sin_cos(2 * lat, dummy, c1);
      sin_cos(2 * last_lat, dummy, c2);
      p = (c1 * c2 + (longint'(1) << 29)) >>> 30;
      t = (p * s2 + (longint'(1) << 29)) >>> 30;
      a = s1 * s1 + t * s2;
      if (a < 0) a = 0;
      if (a > (longint'(1) << 60)) a = longint'(1) << 60;
      z = atan2_q30(longint'(floor_sqrt((longint'(1) << 60) - a)),
                    longint'(floor_sqrt(a)));
      z *= 2;
      if (z < 0) z = 0;
      d = (z * 64'sd636962875 + (longint'(1) << 29)) >>> 30;
      if (d > 64'sh7FFFFFFF) d = 64'sh7FFFFFFF;
      return d;
   endfunction

   function void note_fix(logic signed [30:0] lat, logic signed [31:0] lon);
      fix_result_type e;
      longint d;
      e = '{31'd0, 1'b0, 1'b0, 1'b0};
      if (!have_last) begin
         e.first_fix = 1'b1;
      end else begin
         d = haversine_cm(longint'(lat), longint'(lon));
         e.distance_cm = d[30:0];
         e.zero_move   = (d == 0);
         e.drift_flag  = (d > longint'(drift_limit));
      end
      last_lat  = lat;
      last_lon  = lon;
      have_last = 1;
      pending = {pending, e};
   endfunction

   function void check_result(fix_result_type got);
      fix_result_type e;
      checked++;
      if (got.drift_flag) drifts_seen++;
      if (got.zero_move) zeros_seen++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("ERROR: unexpected result word, distance %0d",
                                    got.distance_cm);
         return;
      end
      e = pending.pop_front();
      if (got.distance_cm !== e.distance_cm || got.zero_move !== e.zero_move ||
          got.drift_flag !== e.drift_flag || got.first_fix !== e.first_fix) begin
         errors++;
         if (errors <= 10)
            $display("ERROR: exp dist %0d zero %b drift %b first %b, got %0d %b %b %b",
                     e.distance_cm, e.zero_move, e.drift_flag, e.first_fix,
                     got.distance_cm, got.zero_move, got.drift_flag, got.first_fix);
      end
   endfunction
endclass

module testbench;
   import gfd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [30:0] csr_write_data = '0;

   gfd_req_if req_bus ();
   gfd_rsp_if rsp_bus ();

   drift_scoreboard fix_board = new();
   bit              stimulus_done = 1'b0;
   int              limits_tried = 0;
   longint          track_lat, track_lon;

   gps_fix_distance_drift_check dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Overall limit: far above the slowest legal run (421 words, plus both
   // sides' longest waits).
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: hold ready low for a random stall before each word, keep it
   // high through runs of zero stalls.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // Check every word accepted on the result side.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         fix_board.check_result('{rsp_bus.distance_cm, rsp_bus.zero_move,
                                  rsp_bus.drift_flag, rsp_bus.first_fix});
   end

   // Offer one fix after a random gap and hold it until accepted. Valid stays
   // high on return so that a zero gap needs no second assignment.
   task automatic send_fix(longint lat, longint lon);
      int gap;
      gap = $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.latitude  <= lat[30:0];
      req_bus.longitude <= lon[31:0];
      do @(posedge clock); while (!req_bus.ready);
      fix_board.note_fix(lat[30:0], lon[31:0]);
   endtask

   // Drop valid, let every expected word arrive, then give the block a short
   // grace period so that it is idle before the limit is changed.
   task automatic drain_fixes();
      req_bus.valid <= 1'b0;
      while (fix_board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_drift_limit(logic [30:0] limit);
      csr_write_en   <= 1'b1;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      fix_board.drift_limit = limit;
      limits_tried++;
   endtask

   // Advance the track by a random step; now and then jump to random bits so
   // that every input bit and out-of-range coordinates are reached.
   task automatic send_track_fix();
      int     pick;
      longint span;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         track_lat = longint'($signed(31'($urandom())));
         track_lon = longint'($signed($urandom()));
      end else if (pick == 1) begin
         // repeat the fix: zero movement
      end else begin
         case ($urandom_range(0, 3))
            0: span = 10;
            1: span = 5000;
            2: span = 60000;
            default: span = 2000000;
         endcase
         track_lat += longint'($urandom_range(0, 2 * span)) - span;
         track_lon += longint'($urandom_range(0, 2 * span)) - span;
         track_lat = longint'($signed(track_lat[30:0]));
         track_lon = longint'($signed(track_lon[31:0]));
      end
      send_fix(track_lat, track_lon);
   endtask

   initial begin
      logic [30:0] limits[5];
      req_bus.valid     = 1'b0;
      req_bus.latitude  = '0;
      req_bus.longitude = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: first fix, zero move, extremes, antipode, quadrant edges,
      // out-of-range latitude and moves straddling the default 500 m limit.
      send_fix(0, 0);
      send_fix(0, 0);
      send_fix(1, 0);
      send_fix(1, 1);
      send_fix(900000000, 1800000000);
      send_fix(-900000000, -1800000000);
      send_fix(900000000, -1800000000);
      send_fix(0, 0);
      send_fix(0, 1800000000);
      send_fix(1073741823, 2147483647);
      send_fix(-1073741824, -2147483648);
      send_fix(1000000000, 0);
      send_fix(1000000000, 0);
      send_fix(-1000000000, 900000000);
      send_fix(515000000, 1000000);
      send_fix(515044900, 1000000);
      send_fix(515090000, 1000000);
      send_fix(515090000, 1071000);
      send_fix(515090000, 1145000);
      send_fix(0, 1);
      send_fix(0, 0);
      drain_fixes();

      // Random phases, each under its own drift limit.
      limits[0] = 31'd0;
      limits[1] = 31'h7FFF_FFFF;
      limits[2] = 31'($urandom_range(1000, 3000000));
      limits[3] = 31'($urandom());
      limits[4] = DRIFT_RESET;
      track_lat = 515000000;
      track_lon = 1000000;
      foreach (limits[p]) begin
         write_drift_limit(limits[p]);
         repeat (80) send_track_fix();
         drain_fixes();
      end
      stimulus_done = 1'b1;
   end

   // Final verdict once all words are back and the block has settled.
   initial begin
      wait (stimulus_done);
      repeat (400) @(posedge clock);
      $display("Checked %0d result words under %0d drift limit settings.",
               fix_board.checked, limits_tried + 1);
      $display("Seen %0d drift flags and %0d zero moves; %0d mismatches.",
               fix_board.drifts_seen, fix_board.zeros_seen, fix_board.errors);
      if (fix_board.errors == 0 && fix_board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/gfd_pkg.sv
rtl/gfd_req_if.sv
rtl/gfd_rsp_if.sv
rtl/gfd_cordic.sv
rtl/gfd_sqdiv.sv
rtl/gps_fix_distance_drift_check.sv
rtl/gfd_checker.sv
tb/testbench.sv
